// ----- rtl/gtsc_pkg.sv -----
// Shared types and constants for the gyro turn-speed controller.
// Used by the controller, the datapath, the divider and the top level; depends on nothing.
`default_nettype none

package gtsc_pkg;

  localparam int unsigned SETTLE_TICKS   = 20;
  localparam int unsigned TOLERANCE_CDEG = 200;

  localparam logic [14:0] SPEED_ONE  = 15'd16384;
  localparam logic [14:0] SPEED_MIN  = 15'd5734;
  localparam logic [14:0] SPEED_RST  = 15'd8192;
  localparam logic [14:0] GROW_Q14   = 15'd16712;
  localparam logic [15:0] NEAR_CDEG  = 16'd2000;
  localparam logic [11:0] ONE_DEG    = 12'd100;
  localparam logic [4:0]  SETTLE_MAX = 5'd31;
  localparam logic [15:0] TICK_MAX   = 16'hFFFF;
  localparam logic [29:0] ROUND_HALF = 30'd8192;

  // Divider sizing: 25-bit product over a 12-bit divisor.
  localparam int unsigned DIV_NUM_W  = 25;
  localparam int unsigned DIV_DEN_W  = 12;
  localparam int unsigned DIV_STEPS  = DIV_NUM_W;
  localparam int unsigned DIV_CNT_W  = $clog2(DIV_STEPS);

  localparam logic [1:0] REG_TARGET  = 2'd0;
  localparam logic [1:0] REG_START   = 2'd1;
  localparam logic [1:0] REG_TIMEOUT = 2'd2;

  typedef struct packed {
    logic load_in;
    logic calc_err;
    logic calc_mul;
    logic div_start;
    logic wrap;
  } gtsc_cmd_t;

  typedef struct packed {
    logic done;
    logic near;
    logic div_done;
  } gtsc_sts_t;

endpackage

`default_nettype wire

// ----- rtl/gtsc_div.sv -----
// Restoring divider, one quotient bit per cycle.
// Depends on gtsc_pkg for its widths.
`default_nettype none

module gtsc_div
  import gtsc_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic [DIV_NUM_W-1:0] num_i,
  input  wire logic [DIV_DEN_W-1:0] den_i,
  output logic                      done_o,
  output logic [DIV_NUM_W-1:0]      quo_o
);

  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

  logic                 busy_q, busy_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DIV_DEN_W-1:0] rem_q, rem_d;
  logic [DIV_DEN_W-1:0] den_q, den_d;
  logic [DIV_NUM_W-1:0] quo_q, quo_d;
  logic [DIV_DEN_W:0]   trial;
  logic [DIV_DEN_W:0]   diff;

  assign trial = {rem_q, quo_q[DIV_NUM_W-1]};
  assign diff  = trial - {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      den_d  = den_i;
      quo_d  = num_i;
    end else if (busy_q) begin
      // The remainder stays below the divisor, so it fits the divisor width.
      if (trial >= {1'b0, den_q}) begin
        rem_d = diff[DIV_DEN_W-1:0];
        quo_d = {quo_q[DIV_NUM_W-2:0], 1'b1};
      end else begin
        rem_d = trial[DIV_DEN_W-1:0];
        quo_d = {quo_q[DIV_NUM_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DIV_LAST) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  assign done_o = busy_q && (cnt_q == DIV_LAST);
  assign quo_o  = quo_q;

endmodule

`default_nettype wire

// ----- rtl/gtsc_dp.sv -----
// Datapath: configuration registers, controller state, speed arithmetic and result register.
// Depends on gtsc_pkg and instantiates gtsc_div.
`default_nettype none

module gtsc_dp
  import gtsc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic [15:0] yaw_sample_i,
  input  wire logic        brownout_i,
  input  wire gtsc_cmd_t   cmd_i,
  output gtsc_sts_t        sts_o,
  output logic [15:0]      left_drive_o,
  output logic [15:0]      right_drive_o,
  output logic             finished_o,
  output logic             timed_out_o
);

  logic [15:0] target_q;
  logic [15:0] timeout_q;
  logic [14:0] turn_speed_q;
  logic [4:0]  settle_q;
  logic [15:0] tick_q;
  logic        done_q;
  logic        tmo_latch_q;

  logic [15:0] yaw_q;
  logic        brown_q;
  logic        err_neg_q;
  logic [15:0] mag_q;
  logic        near_q;
  logic        hit_q;
  logic [14:0] spd_q;
  logic [29:0] prod_q;

  logic [15:0] left_q, right_q;
  logic        fin_q, tmo_q;

  logic [16:0] err;
  logic [15:0] mag;
  logic [14:0] spd_sel;
  logic [14:0] mul_op;
  logic [29:0] prod;
  logic [29:0] rounded;
  logic [14:0] cand;
  logic [14:0] spd_new;
  logic [15:0] spd16;
  logic [4:0]  settle_next;
  logic [15:0] tick_next;
  logic        tmo;
  logic        fin;
  logic        div_done;
  logic [DIV_NUM_W-1:0] quo;
  logic [DIV_DEN_W-1:0] den;

  // Error and its magnitude from the captured sample.
  assign err = {1'b0, yaw_q} - {1'b0, target_q};
  assign mag = err[16] ? 16'(-err) : err[15:0];
  assign spd_sel = brown_q ? SPEED_MIN : turn_speed_q;

  // One multiplier serves both the near-target scale and the 1.02 growth.
  assign mul_op = near_q ? {4'b0, mag_q[10:0]} : GROW_Q14;
  assign prod   = spd_q * mul_op;

  assign den = {1'b0, mag_q[10:0]} + ONE_DEG;

  gtsc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.div_start),
    .num_i  (prod_q[DIV_NUM_W-1:0]),
    .den_i  (den),
    .done_o (div_done),
    .quo_o  (quo)
  );

  assign rounded = prod_q + ROUND_HALF;
  assign cand    = near_q ? quo[14:0] : rounded[28:14];
  assign spd_new = (cand < SPEED_MIN) ? SPEED_MIN : cand;
  assign spd16   = {1'b0, spd_new};

  assign settle_next = hit_q ? ((settle_q < SETTLE_MAX) ? settle_q + 1'b1 : settle_q) : '0;
  assign tick_next   = (tick_q < TICK_MAX) ? tick_q + 1'b1 : tick_q;
  assign tmo = (timeout_q != '0) && (tick_next >= timeout_q);
  assign fin = tmo || (settle_next > 5'(SETTLE_TICKS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q     <= '0;
      timeout_q    <= '0;
      turn_speed_q <= SPEED_RST;
      settle_q     <= '0;
      tick_q       <= '0;
      done_q       <= 1'b0;
      tmo_latch_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_TARGET:  target_q <= cfg_data_i;
          REG_START:   turn_speed_q <= cfg_data_i[14:0];
          REG_TIMEOUT: timeout_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.wrap && !done_q) begin
        turn_speed_q <= spd_new;
        settle_q     <= settle_next;
        tick_q       <= tick_next;
        if (fin) begin
          done_q      <= 1'b1;
          tmo_latch_q <= tmo;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      yaw_q   <= yaw_sample_i;
      brown_q <= brownout_i;
    end
    if (cmd_i.calc_err) begin
      err_neg_q <= err[16];
      mag_q     <= mag;
      near_q    <= mag < NEAR_CDEG;
      hit_q     <= mag < 16'(TOLERANCE_CDEG);
      spd_q     <= (spd_sel > SPEED_ONE) ? SPEED_ONE : spd_sel;
    end
    if (cmd_i.calc_mul) begin
      prod_q <= prod;
    end
    if (cmd_i.wrap) begin
      if (done_q) begin
        left_q  <= '0;
        right_q <= '0;
        fin_q   <= 1'b1;
        tmo_q   <= tmo_latch_q;
      end else if (fin) begin
        left_q  <= '0;
        right_q <= '0;
        fin_q   <= 1'b1;
        tmo_q   <= tmo;
      end else begin
        // A negative error turns with the left wheel forward.
        left_q  <= err_neg_q ? spd16 : 16'(-spd16);
        right_q <= err_neg_q ? 16'(-spd16) : spd16;
        fin_q   <= 1'b0;
        tmo_q   <= 1'b0;
      end
    end
  end

  assign sts_o.done     = done_q;
  assign sts_o.near     = near_q;
  assign sts_o.div_done = div_done;

  assign left_drive_o  = left_q;
  assign right_drive_o = right_q;
  assign finished_o    = fin_q;
  assign timed_out_o   = tmo_q;

  a_done_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> done_q)
    else $error("finish flag cleared without reset");

  a_speed_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.wrap && !done_q && !cfg_we_i) |=> (turn_speed_q >= SPEED_MIN))
    else $error("turn speed fell below the floor after an update");

endmodule

`default_nettype wire

// ----- rtl/gtsc_ctrl.sv -----
// Controller state machine: sequences one request through the datapath and owns both handshakes.
// Depends on gtsc_pkg for the command and status structs.
`default_nettype none

module gtsc_ctrl
  import gtsc_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  input  wire gtsc_sts_t sts_i,
  output gtsc_cmd_t      cmd_o
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_ERR  = 6'b000010,
    S_MUL  = 6'b000100,
    S_DST  = 6'b001000,
    S_DIV  = 6'b010000,
    S_WRAP = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;
  logic   slot_free;

  assign accept    = in_valid_i && in_ready_o;
  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          // A finished block answers at once with the held result.
          state_d = sts_i.done ? S_WRAP : S_ERR;
        end
      end
      S_ERR: begin
        cmd_o.calc_err = 1'b1;
        state_d = S_MUL;
      end
      S_MUL: begin
        cmd_o.calc_mul = 1'b1;
        state_d = sts_i.near ? S_DST : S_WRAP;
      end
      S_DST: begin
        cmd_o.div_start = 1'b1;
        state_d = S_DIV;
      end
      S_DIV: begin
        if (sts_i.div_done) begin
          state_d = S_WRAP;
        end
      end
      S_WRAP: begin
        if (slot_free) begin
          cmd_o.wrap = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.wrap) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.wrap |-> (!out_valid_q || out_ready_i))
    else $error("result written over one not yet taken");

  a_div_in_place: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.div_done |-> (state_q == S_DIV))
    else $error("divider finished outside its wait state");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_ready_o)
    else $error("second request taken while one is in work");

endmodule

`default_nettype wire

// ----- rtl/gyro_turn_speed_controller.sv -----
// Top level of the gyro turn-speed controller.
// Depends on gtsc_pkg and instantiates gtsc_ctrl and gtsc_dp.
`default_nettype none

// One request per control tick carries a yaw sample in centidegrees and a brown-out
// flag; each gives exactly one result with signed Q14 wheel drives and the finish flags.
// Requests are handled one at a time. A request with a heading error of 20 degrees
// or more passes through the error and multiply states to the result; a nearer one
// also runs the 25-step restoring divider forming speed*|e|/(|e|+100), and a
// finished block answers at once. A result waits in an output register, so
// the next request is taken while it is still unclaimed. Configuration writes are
// always ready; a write of start_speed also reloads the turn speed.
module gyro_turn_speed_controller
  import gtsc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [15:0] yaw_sample_i,
  input  wire logic        brownout_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [15:0]      left_drive_o,
  output logic [15:0]      right_drive_o,
  output logic             finished_o,
  output logic             timed_out_o
);

  gtsc_cmd_t cmd;
  gtsc_sts_t sts;

  assign cfg_ready_o = 1'b1;

  gtsc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  gtsc_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .yaw_sample_i (yaw_sample_i),
    .brownout_i   (brownout_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .left_drive_o (left_drive_o),
    .right_drive_o(right_drive_o),
    .finished_o   (finished_o),
    .timed_out_o  (timed_out_o)
  );

endmodule

`default_nettype wire

// ----- bench/tb_gyro_turn_speed_controller.sv -----
// Self-checking testbench for gyro_turn_speed_controller: random and directed yaw requests
// with random handshake gaps, each result checked against an in-bench heading-loop predictor.
// Depends on gtsc_pkg and the RTL of the controller.
module tb_gyro_turn_speed_controller;
  import gtsc_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int END_WAIT = 40;
  localparam int MAX_PRINTED = 40;
  localparam logic [1:0] REG_NONE = 2'd3;

  typedef struct packed {
    logic [15:0] yaw;
    logic        brown;
    logic        drain_first;
  } tick_req_t;

  typedef struct packed {
    logic [15:0] left;
    logic [15:0] right;
    logic        finished;
    logic        timed_out;
  } drive_t;

  typedef enum logic [1:0] {FIN_SETTLE, FIN_TIMEOUT, FIN_BOTH} finish_kind_e;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [1:0]  cfg_index = REG_TARGET;
  logic [15:0] cfg_data = 16'd0;
  logic        in_valid = 1'b0;
  logic [15:0] yaw_drv = 16'd0;
  logic        brown_drv = 1'b0;
  logic        out_ready = 1'b0;
  logic        cfg_ready;
  logic        in_ready;
  logic        out_valid;
  logic [15:0] left_drive;
  logic [15:0] right_drive;
  logic        finished;
  logic        timed_out;

  // Register copies and loop state of the predictor.
  logic [15:0] set_target = 16'd0;
  logic [14:0] set_start = SPEED_RST;
  logic [15:0] set_timeout = 16'd0;
  logic [14:0] pred_speed = SPEED_RST;
  logic [4:0]  pred_settle = 5'd0;
  logic [15:0] pred_ticks = 16'd0;
  logic        pred_done = 1'b0;
  logic        pred_tmo = 1'b0;

  tick_req_t tick_reqs[$];
  drive_t    expected_drives[$];
  logic      req_on_port = 1'b0;
  logic      calm = 1'b0;
  int        near_run = 0;
  int        req_gap = 0;
  int        res_stall = 0;
  int        mismatches = 0;
  int        cycle_cnt = 0;

  gyro_turn_speed_controller u_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .yaw_sample_i  (yaw_drv),
    .brownout_i    (brown_drv),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .left_drive_o  (left_drive),
    .right_drive_o (right_drive),
    .finished_o    (finished),
    .timed_out_o   (timed_out)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic log_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_PRINTED) $display("cycle %0d: mismatch: %s", cycle_cnt, what);
  endtask

  // Computes the drive for one tick and advances the loop state.
  function automatic drive_t predict_drive(input logic [15:0] yaw, input logic brown);
    drive_t      r;
    int          err;
    logic [31:0] mag;
    logic [31:0] spd;
    logic [15:0] s16;
    logic        tmo;
    r = '0;
    if (pred_done) begin
      r.finished = 1'b1;
      r.timed_out = pred_tmo;
      return r;
    end
    err = int'(yaw) - int'(set_target);
    mag = (err < 0) ? -err : err;
    spd = 32'(pred_speed);
    if (brown) spd = 32'(SPEED_MIN);
    if (spd > SPEED_ONE) spd = 32'(SPEED_ONE);
    if (mag < NEAR_CDEG) spd = (spd * mag) / (mag + ONE_DEG);
    else spd = (spd * GROW_Q14 + ROUND_HALF) >> 14;
    if (spd < SPEED_MIN) spd = 32'(SPEED_MIN);
    pred_speed = spd[14:0];
    s16 = spd[15:0];
    // A negative error turns with the left wheel forward.
    if (err < 0) begin
      r.left = s16;
      r.right = -s16;
    end else begin
      r.left = -s16;
      r.right = s16;
    end
    if (mag < TOLERANCE_CDEG) begin
      if (pred_settle != SETTLE_MAX) pred_settle++;
    end else begin
      pred_settle = 5'd0;
    end
    if (pred_ticks != TICK_MAX) pred_ticks++;
    tmo = (set_timeout != 16'd0) && (pred_ticks >= set_timeout);
    if (tmo || pred_settle > SETTLE_TICKS) begin
      pred_done = 1'b1;
      pred_tmo = tmo;
      r = '0;
      r.finished = 1'b1;
      r.timed_out = tmo;
    end
    return r;
  endfunction

  // Queues one request and tracks how many in-tolerance samples have come in a row.
  function automatic void queue_tick(input logic [15:0] yaw, input logic brown,
                                     input logic drain);
    int        delta;
    tick_req_t req;
    delta = int'(yaw) - int'(set_target);
    if (delta < 0) delta = -delta;
    if (delta < TOLERANCE_CDEG) near_run++;
    else near_run = 0;
    req.yaw = yaw;
    req.brown = brown;
    req.drain_first = drain;
    tick_reqs.push_back(req);
  endfunction

  function automatic logic [15:0] far_yaw();
    if (set_target >= 16'd10000) return set_target - 16'($urandom_range(200, 9999));
    return set_target + 16'($urandom_range(200, 9999));
  endfunction

  function automatic logic [15:0] near_yaw();
    int off;
    int v;
    off = int'($urandom_range(0, 398)) - 199;
    v = int'(set_target) + off;
    if (v < 0 || v > 65535) v = int'(set_target) - off;
    return v[15:0];
  endfunction

  // Called right after a rising edge; returns at the next edge after the write is taken.
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    cfg_index <= idx;
    cfg_data <= data;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_TARGET: set_target = data;
      REG_START: begin
        set_start = data[14:0];
        pred_speed = data[14:0];
      end
      REG_TIMEOUT: set_timeout = data;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic wait_idle();
    while (tick_reqs.size() != 0 || req_on_port || expected_drives.size() != 0)
      @(posedge clk);
  endtask

  always @(posedge clk or negedge rst_n) begin : req_driver
    tick_req_t nxt;
    logic      valid_n;
    int        gap_n;
    if (!rst_n) begin
      in_valid <= 1'b0;
      req_gap <= 0;
      req_on_port = 1'b0;
    end else begin
      valid_n = in_valid;
      gap_n = req_gap;
      if (in_valid && in_ready) begin
        expected_drives.push_back(predict_drive(yaw_drv, brown_drv));
        req_on_port = 1'b0;
        valid_n = 1'b0;
        gap_n = calm ? 0 : $urandom_range(0, 15);
      end
      if (!valid_n) begin
        if (gap_n > 0) begin
          gap_n--;
        end else if (tick_reqs.size() != 0 &&
                     !(tick_reqs[0].drain_first && expected_drives.size() != 0)) begin
          nxt = tick_reqs.pop_front();
          yaw_drv <= nxt.yaw;
          brown_drv <= nxt.brown;
          valid_n = 1'b1;
          req_on_port = 1'b1;
        end
      end
      in_valid <= valid_n;
      req_gap <= gap_n;
    end
  end

  always @(posedge clk or negedge rst_n) begin : drive_monitor
    drive_t want;
    int     stall_n;
    if (!rst_n) begin
      out_ready <= 1'b0;
      res_stall <= 0;
    end else begin
      stall_n = res_stall;
      if (out_valid && out_ready) begin
        if (expected_drives.size() == 0) begin
          log_mismatch("result with no request outstanding");
        end else begin
          want = expected_drives.pop_front();
          if (left_drive !== want.left)
            log_mismatch($sformatf("left_drive got %0d want %0d",
                                   $signed(left_drive), $signed(want.left)));
          if (right_drive !== want.right)
            log_mismatch($sformatf("right_drive got %0d want %0d",
                                   $signed(right_drive), $signed(want.right)));
          if (finished !== want.finished)
            log_mismatch($sformatf("finished got %b want %b", finished, want.finished));
          if (timed_out !== want.timed_out)
            log_mismatch($sformatf("timed_out got %b want %b", timed_out, want.timed_out));
        end
        stall_n = calm ? 0 : $urandom_range(0, 15);
      end
      if (stall_n > 0) begin
        stall_n--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
      res_stall <= stall_n;
    end
  end

  initial begin : stimulus
    int           r;
    int           off;
    int           v;
    int           burst_left;
    int           phase;
    int           i;
    logic [15:0]  yaw;
    logic         brown;
    finish_kind_e fin_kind;
    burst_left = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset values: target 0, start speed 0.5, no timeout.
    queue_tick(16'd0, 1'b0, 1'b0);
    queue_tick(16'd199, 1'b0, 1'b0);
    queue_tick(16'd200, 1'b0, 1'b0);
    queue_tick(16'd1999, 1'b0, 1'b0);
    queue_tick(16'd2000, 1'b1, 1'b0);
    queue_tick(16'd35999, 1'b0, 1'b1);
    queue_tick(16'hFFFF, 1'b0, 1'b0);
    queue_tick(16'hFFFF, 1'b1, 1'b0);
    wait_idle();
    write_reg(REG_TARGET, 16'd35999);
    write_reg(REG_START, 16'hFFFF);
    write_reg(REG_TIMEOUT, 16'hFFFF);
    write_reg(REG_NONE, 16'h5A5A);
    queue_tick(16'd0, 1'b0, 1'b0);
    queue_tick(16'd35999, 1'b0, 1'b0);
    queue_tick(16'd35800, 1'b1, 1'b0);
    queue_tick(16'd35799, 1'b0, 1'b0);
    queue_tick(16'd34000, 1'b0, 1'b0);
    queue_tick(16'd33999, 1'b0, 1'b1);
    queue_tick(16'hFFFF, 1'b0, 1'b0);
    queue_tick(16'd36198, 1'b0, 1'b0);
    wait_idle();
    // Target beyond one turn and a zero start speed.
    write_reg(REG_TARGET, 16'hFFFF);
    write_reg(REG_START, 16'd0);
    write_reg(REG_TIMEOUT, 16'd0);
    queue_tick(16'hFFFF, 1'b0, 1'b0);
    queue_tick(16'd63536, 1'b0, 1'b0);
    queue_tick(16'd0, 1'b1, 1'b0);
    queue_tick(16'd63535, 1'b0, 1'b0);
    wait_idle();

    for (phase = 0; phase < 8; phase++) begin
      calm = (phase % 3 == 2);
      if (phase == 0 || $urandom_range(0, 3) != 0) begin
        r = $urandom_range(0, 9);
        if (r == 0) write_reg(REG_TARGET, 16'd0);
        else if (r == 1) write_reg(REG_TARGET, 16'd35999);
        else if (r == 2) write_reg(REG_TARGET, 16'($urandom_range(0, 65535)));
        else write_reg(REG_TARGET, 16'($urandom_range(0, 35999)));
      end
      if (phase == 0) begin
        write_reg(REG_START, 16'd16384);
      end else if ($urandom_range(0, 2) != 0) begin
        r = $urandom_range(0, 5);
        if (r == 0) write_reg(REG_START, 16'd0);
        else if (r == 1) write_reg(REG_START, 16'd16384);
        else if (r == 2) write_reg(REG_START, 16'($urandom_range(0, 65535)));
        else write_reg(REG_START, 16'($urandom_range(0, 16384)));
      end
      // Timeouts stay far above the tick count reached before the closing phase.
      if ($urandom_range(0, 2) == 0) begin
        r = $urandom_range(0, 2);
        if (r == 0) write_reg(REG_TIMEOUT, 16'd0);
        else if (r == 1) write_reg(REG_TIMEOUT, 16'hFFFF);
        else write_reg(REG_TIMEOUT, 16'($urandom_range(20000, 65535)));
      end
      if ($urandom_range(0, 3) == 0) write_reg(REG_NONE, 16'($urandom_range(0, 65535)));

      for (i = 0; i < 200; i++) begin
        r = $urandom_range(0, 99);
        brown = ($urandom_range(0, 99) < 15);
        if (burst_left > 0) begin
          burst_left--;
          yaw = near_yaw();
        end else if (r < 5) begin
          burst_left = $urandom_range(8, 20);
          yaw = near_yaw();
        end else if (r < 35) begin
          yaw = near_yaw();
        end else if (r < 65) begin
          off = int'($urandom_range(0, 4398)) - 2199;
          v = int'(set_target) + off;
          if (v < 0 || v > 65535) v = int'(set_target) - off;
          yaw = v[15:0];
        end else if (r < 90) begin
          yaw = 16'($urandom_range(0, 35999));
        end else begin
          yaw = 16'($urandom_range(0, 65535));
        end
        // Twenty settled ticks in a row is the most allowed before the closing phase.
        if (near_run >= SETTLE_TICKS) yaw = far_yaw();
        queue_tick(yaw, brown, $urandom_range(0, 99) == 0);
      end
      wait_idle();
    end

    // Closing phase: the block finishes once, so the finish path is taken at the end.
    calm = 1'b0;
    queue_tick(far_yaw(), 1'b0, 1'b0);
    wait_idle();
    fin_kind = finish_kind_e'($urandom_range(0, 2));
    case (fin_kind)
      FIN_SETTLE: begin
        write_reg(REG_TIMEOUT, 16'd0);
        repeat (SETTLE_TICKS + 1) queue_tick(near_yaw(), $urandom_range(0, 3) == 0, 1'b0);
      end
      FIN_TIMEOUT: begin
        write_reg(REG_TIMEOUT, pred_ticks + 16'($urandom_range(1, 8)));
        repeat (12) queue_tick(far_yaw(), $urandom_range(0, 3) == 0, 1'b0);
      end
      default: begin
        // Settling and the timeout land on the same tick.
        write_reg(REG_TIMEOUT, pred_ticks + 16'(SETTLE_TICKS + 1));
        repeat (SETTLE_TICKS + 1) queue_tick(near_yaw(), 1'b0, 1'b0);
      end
    endcase
    for (i = 0; i < 10; i++)
      queue_tick(16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)), i == 5);
    wait_idle();

    repeat (END_WAIT) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
